// ===== sv/bae_pkg.sv =====
// ----------------------------------------------------------------------------
// bae_pkg
// Shared widths, codes and the log2 table function of the barometric
// altitude filter.
// ----------------------------------------------------------------------------
package bae_pkg;

	localparam int PRESSURE_FRAC_BITS_DEF = 8;
	localparam int LN_TABLE_DEPTH_DEF     = 64;

	localparam int PRESSURE_W = 17;
	localparam int GAIN_W     = 16;
	localparam int TEMP_W     = 15;
	localparam int SCALE_W    = 32;
	localparam int ALT_W      = 32;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int FRAC_W    = 30;
	localparam int TAB_W     = 31;
	localparam int MUL_W     = 34;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ACC_W     = 96;
	localparam int LOG_W     = 37;
	localparam int DMAG_W    = 36;
	localparam int LM_W      = 36;
	localparam int PM_W      = 46;
	localparam int LIMB_W    = 32;
	localparam int ALT_SHIFT = 50;
	localparam int MAG_W     = ACC_W - ALT_SHIFT;

	localparam int LN2_Q26   = 46516320;
	localparam int LN2_SHIFT = 26;
	localparam int LN_ROUND  = (1 << LN2_SHIFT) - 1;
	localparam int EMA_ROUND = 32768;
	localparam int GAIN_ONE  = 65536;

	localparam logic [63:0] ONE_Q30 = 64'd1 << FRAC_W;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOSET = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd3;

	typedef struct packed {
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_op_t;

	// log2 of a q30 value in [1,2), one result bit per squaring
	function automatic logic [TAB_W-1:0] bit_log2(input logic [63:0] y_in);
		logic [63:0] y;
		logic [TAB_W-1:0] r;
		y = y_in;
		r = '0;
		for (int k = 0; k < FRAC_W; k++) begin
			y = (y * y) >> FRAC_W;
			r = r << 1;
			if (y >= (ONE_Q30 << 1)) begin
				y = y >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/bae_mul.sv =====
// ----------------------------------------------------------------------------
// bae_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module bae_mul
	import bae_pkg::*;
(
	input  logic              clk,
	input  mul_op_t           op,
	output logic [PROD_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= {{MUL_W{1'b0}}, op.a} * {{MUL_W{1'b0}}, op.b};
	end

endmodule

// ===== sv/bae_log_tab.sv =====
// ----------------------------------------------------------------------------
// bae_log_tab
// Constant table of log2 over the mantissa segments, q30, with the end
// point 1.0 after the last segment.
// ----------------------------------------------------------------------------
module bae_log_tab
	import bae_pkg::*;
#(
	parameter int LN_TABLE_DEPTH = LN_TABLE_DEPTH_DEF,
	parameter int ADDR_W         = $clog2(LN_TABLE_DEPTH + 1)
) (
	input  logic [ADDR_W-1:0] addr,
	output logic [TAB_W-1:0]  data
);

	localparam int ROWS = 1 << ADDR_W;

	logic [TAB_W-1:0] rom [ROWS];

	for (genvar i = 0; i < ROWS; i++) begin : g_row
		localparam logic [63:0] Y = ONE_Q30 + ((64'(i) << FRAC_W) / LN_TABLE_DEPTH);
		if (i < LN_TABLE_DEPTH) begin : g_seg
			assign rom[i] = bit_log2(Y);
		end else begin : g_end
			assign rom[i] = TAB_W'(ONE_Q30);
		end
	end

	assign data = rom[addr];

endmodule

// ===== sv/baro_altitude_ema.sv =====
// ----------------------------------------------------------------------------
// baro_altitude_ema
// Barometric altitude with an exponential moving average of the pressure.
// ----------------------------------------------------------------------------
// raw_pressure requests enter on sample_valid / sample_stall, results leave
// on result_valid / result_stall; a request moves when valid is high and
// stall is low. cfg_we writes register cfg_index with cfg_data.
// A zero sample is taken and dropped; the block is ready again next cycle.
// A nonzero sample holds sample_stall high while a small sequencer drives
// one shared multiplier, a binary-search normalizer and the log2 table
// through the two log2 evaluations and the multi-limb products.
// With ground pressure zero the log2 steps are skipped and the result
// gives altitude 0, status 2. A result stalled downstream holds in the
// output register; the next sample is still taken and waits at the end
// of its run for the slot. Reset clears the filter (first sample seeds it)
// and loads register defaults.
// ----------------------------------------------------------------------------
module baro_altitude_ema
	import bae_pkg::*;
#(
	parameter int PRESSURE_FRAC_BITS = PRESSURE_FRAC_BITS_DEF,
	parameter int LN_TABLE_DEPTH     = LN_TABLE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic [PRESSURE_W-1:0]   raw_pressure,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [PRESSURE_W-1:0]   smoothed_pressure,
	output logic signed [ALT_W-1:0] altitude,
	output logic [STATUS_W-1:0]     status
);

	localparam int XW      = PRESSURE_W + PRESSURE_FRAC_BITS;
	localparam int NSTEP   = $clog2(XW);
	localparam int STEP_W  = $clog2(NSTEP);
	localparam int ADDR_W  = $clog2(LN_TABLE_DEPTH + 1);

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
	localparam logic [ST_W-1:0] ST_EMA1 = 5'd1;
	localparam logic [ST_W-1:0] ST_EMA2 = 5'd2;
	localparam logic [ST_W-1:0] ST_EMA3 = 5'd3;
	localparam logic [ST_W-1:0] ST_NORM = 5'd4;
	localparam logic [ST_W-1:0] ST_POS  = 5'd5;
	localparam logic [ST_W-1:0] ST_IDX  = 5'd6;
	localparam logic [ST_W-1:0] ST_LO   = 5'd7;
	localparam logic [ST_W-1:0] ST_HI   = 5'd8;
	localparam logic [ST_W-1:0] ST_INT  = 5'd9;
	localparam logic [ST_W-1:0] ST_LOG  = 5'd10;
	localparam logic [ST_W-1:0] ST_LN1  = 5'd11;
	localparam logic [ST_W-1:0] ST_LN2  = 5'd12;
	localparam logic [ST_W-1:0] ST_LN3  = 5'd13;
	localparam logic [ST_W-1:0] ST_KT   = 5'd14;
	localparam logic [ST_W-1:0] ST_P0   = 5'd15;
	localparam logic [ST_W-1:0] ST_P1   = 5'd16;
	localparam logic [ST_W-1:0] ST_P2   = 5'd17;
	localparam logic [ST_W-1:0] ST_P3   = 5'd18;
	localparam logic [ST_W-1:0] ST_P4   = 5'd19;
	localparam logic [ST_W-1:0] ST_FIN  = 5'd20;
	localparam logic [ST_W-1:0] ST_OUT  = 5'd21;

	// control
	logic [ST_W-1:0]       state_q;
	logic [STEP_W-1:0]     step_q;
	logic                  side_q;
	logic                  result_valid_q;
	logic [GAIN_W-1:0]     gain_q;
	logic [PRESSURE_W-1:0] ground_q;
	logic [TEMP_W-1:0]     temp_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [XW-1:0]         filt_q;

	// datapath
	logic [PRESSURE_W-1:0] samp_q;
	logic [ACC_W-1:0]      acc_q;
	logic [XW-1:0]         x_q;
	logic [NSTEP-1:0]      lz_q;
	logic [ADDR_W-1:0]     idx_q;
	logic [FRAC_W-1:0]     rem_q;
	logic [TAB_W-1:0]      lo_q;
	logic [TAB_W-1:0]      diff_q;
	logic [LOG_W-1:0]      loga_q;
	logic                  dneg_q;
	logic [DMAG_W-1:0]     dmag_q;
	logic [LM_W-1:0]       lm_q;
	logic [PM_W-1:0]       pm_q;
	logic [ALT_W-1:0]      alt_r_q;
	logic [STATUS_W-1:0]   st_r_q;
	logic [PRESSURE_W-1:0] smoothed_q;
	logic [ALT_W-1:0]      altitude_q;
	logic [STATUS_W-1:0]   status_q;

	mul_op_t             mul_op;
	logic [PROD_W-1:0]   p_q;
	logic [ADDR_W-1:0]   tab_addr;
	logic [TAB_W-1:0]    tab_data;

	logic                  accept;
	logic                  out_free;
	logic [ACC_W-1:0]      ema_sum;
	logic [XW-1:0]         ema_new;
	logic [NSTEP-1:0]      shamt;
	logic [NSTEP:0]        keep_bits;
	logic                  top_zero;
	logic [XW+FRAC_W-1:0]  x_ext;
	logic [FRAC_W-1:0]     frac;
	logic [ADDR_W-1:0]     idx_raw;
	logic [NSTEP-1:0]      expo;
	logic [LOG_W-1:0]      log_now;
	logic signed [LOG_W:0] d_diff;
	logic signed [LOG_W:0] d_abs;
	logic [ACC_W-1:0]      ln_prod;
	logic [ACC_W-1:0]      ln_adj;
	logic [SCALE_W-1:0]    kmag;
	logic [TEMP_W-1:0]     tmag;
	logic [MAG_W-1:0]      mag;
	logic                  neg_eff;
	logic [ALT_W-1:0]      alt_fin;
	logic [STATUS_W-1:0]   st_fin;
	logic [PRESSURE_W-1:0] gain_rest;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;

	assign result_valid      = result_valid_q;
	assign smoothed_pressure = smoothed_q;
	assign altitude          = altitude_q;
	assign status            = status_q;

	// filter update
	assign ema_sum = acc_q + (ACC_W'(p_q) << PRESSURE_FRAC_BITS) + ACC_W'(EMA_ROUND);
	assign ema_new = (filt_q == '0) ? XW'({samp_q, {PRESSURE_FRAC_BITS{1'b0}}})
	                                : ema_sum[GAIN_W +: XW];
	assign gain_rest = PRESSURE_W'(GAIN_ONE) - PRESSURE_W'(gain_q);

	// normalizer step
	assign shamt     = NSTEP'(1) << step_q;
	assign keep_bits = (NSTEP+1)'(XW) - (NSTEP+1)'(shamt);
	assign top_zero  = ((x_q >> keep_bits) == '0);

	// mantissa and log2
	assign x_ext   = {x_q, {FRAC_W{1'b0}}};
	assign frac    = x_ext[XW+FRAC_W-2 -: FRAC_W];
	assign idx_raw = p_q[FRAC_W +: ADDR_W];
	assign expo    = NSTEP'(XW - 1) - lz_q;
	assign log_now = (LOG_W'(expo) << FRAC_W) + LOG_W'(lo_q) + LOG_W'(p_q >> FRAC_W);
	assign d_diff  = $signed({1'b0, loga_q}) - $signed({1'b0, log_now});
	assign d_abs   = d_diff[LOG_W] ? -d_diff : d_diff;

	// ln scaling, floor for negative values
	assign ln_prod = acc_q + (ACC_W'(p_q) << LIMB_W);
	assign ln_adj  = ln_prod + (dneg_q ? ACC_W'(LN_ROUND) : '0);

	assign kmag = scale_q[SCALE_W-1] ? -scale_q : scale_q;
	assign tmag = temp_q[TEMP_W-1] ? -temp_q : temp_q;

	// saturation
	assign mag     = acc_q[ACC_W-1:ALT_SHIFT];
	assign neg_eff = (scale_q[SCALE_W-1] ^ temp_q[TEMP_W-1] ^ dneg_q)
	                 && (pm_q != '0) && (lm_q != '0);

	always_comb begin
		alt_fin = mag[ALT_W-1:0];
		st_fin  = STATUS_OK;
		if (neg_eff) begin
			if (mag > MAG_W'(33'h1_0000_0000 >> 1)) begin
				alt_fin = {1'b1, {(ALT_W-1){1'b0}}};
				st_fin  = STATUS_SAT;
			end else begin
				alt_fin = -mag[ALT_W-1:0];
			end
		end else if (mag > MAG_W'({1'b0, {(ALT_W-1){1'b1}}})) begin
			alt_fin = {1'b0, {(ALT_W-1){1'b1}}};
			st_fin  = STATUS_SAT;
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_op = '0;
		case (state_q)
			ST_EMA1: begin
				mul_op.a = MUL_W'(filt_q);
				mul_op.b = MUL_W'(gain_q);
			end
			ST_EMA2: begin
				mul_op.a = MUL_W'(gain_rest);
				mul_op.b = MUL_W'(samp_q);
			end
			ST_POS: begin
				mul_op.a = MUL_W'(frac);
				mul_op.b = MUL_W'(LN_TABLE_DEPTH);
			end
			ST_INT: begin
				mul_op.a = MUL_W'(diff_q);
				mul_op.b = MUL_W'(rem_q);
			end
			ST_LN1: begin
				mul_op.a = MUL_W'(dmag_q[LIMB_W-1:0]);
				mul_op.b = MUL_W'(LN2_Q26);
			end
			ST_LN2: begin
				mul_op.a = MUL_W'(dmag_q[DMAG_W-1:LIMB_W]);
				mul_op.b = MUL_W'(LN2_Q26);
			end
			ST_LN3: begin
				mul_op.a = MUL_W'(kmag);
				mul_op.b = MUL_W'(tmag);
			end
			ST_P0: begin
				mul_op.a = MUL_W'(pm_q[LIMB_W-1:0]);
				mul_op.b = MUL_W'(lm_q[LIMB_W-1:0]);
			end
			ST_P1: begin
				mul_op.a = MUL_W'(pm_q[LIMB_W-1:0]);
				mul_op.b = MUL_W'(lm_q[LM_W-1:LIMB_W]);
			end
			ST_P2: begin
				mul_op.a = MUL_W'(pm_q[PM_W-1:LIMB_W]);
				mul_op.b = MUL_W'(lm_q[LIMB_W-1:0]);
			end
			ST_P3: begin
				mul_op.a = MUL_W'(pm_q[PM_W-1:LIMB_W]);
				mul_op.b = MUL_W'(lm_q[LM_W-1:LIMB_W]);
			end
			default: mul_op = '0;
		endcase
	end

	assign tab_addr = (state_q == ST_HI) ? idx_q + ADDR_W'(1) : idx_q;

	bae_mul u_mul (
		.clk (clk),
		.op  (mul_op),
		.p_q (p_q)
	);

	bae_log_tab #(
		.LN_TABLE_DEPTH (LN_TABLE_DEPTH),
		.ADDR_W         (ADDR_W)
	) u_tab (
		.addr (tab_addr),
		.data (tab_data)
	);

	// sequencer, registers and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			side_q         <= 1'b0;
			result_valid_q <= 1'b0;
			gain_q         <= GAIN_W'(58982);
			ground_q       <= '0;
			temp_q         <= TEMP_W'(2000);
			scale_q        <= SCALE_W'(-30);
			filt_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
					CFG_GROUND: ground_q <= cfg_data[PRESSURE_W-1:0];
					CFG_TEMP:   temp_q   <= cfg_data[TEMP_W-1:0];
					CFG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
					default:    ;
				endcase
			end
			if (state_q == ST_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && raw_pressure != '0) begin
						state_q <= ST_EMA1;
					end
				end
				ST_EMA1: state_q <= ST_EMA2;
				ST_EMA2: state_q <= ST_EMA3;
				ST_EMA3: begin
					filt_q <= ema_new;
					side_q <= 1'b0;
					step_q <= STEP_W'(NSTEP - 1);
					state_q <= (ground_q == '0) ? ST_OUT : ST_NORM;
				end
				ST_NORM: begin
					if (step_q == '0) begin
						state_q <= ST_POS;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_POS: state_q <= ST_IDX;
				ST_IDX: state_q <= ST_LO;
				ST_LO:  state_q <= ST_HI;
				ST_HI:  state_q <= ST_INT;
				ST_INT: state_q <= ST_LOG;
				ST_LOG: begin
					if (!side_q) begin
						side_q  <= 1'b1;
						step_q  <= STEP_W'(NSTEP - 1);
						state_q <= ST_NORM;
					end else begin
						state_q <= ST_LN1;
					end
				end
				ST_LN1: state_q <= ST_LN2;
				ST_LN2: state_q <= ST_LN3;
				ST_LN3: state_q <= ST_KT;
				ST_KT:  state_q <= ST_P0;
				ST_P0:  state_q <= ST_P1;
				ST_P1:  state_q <= ST_P2;
				ST_P2:  state_q <= ST_P3;
				ST_P3:  state_q <= ST_P4;
				ST_P4:  state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					samp_q <= raw_pressure;
				end
			end
			ST_EMA2: acc_q <= ACC_W'(p_q);
			ST_EMA3: begin
				x_q     <= ema_new;
				lz_q    <= '0;
				alt_r_q <= '0;
				st_r_q  <= STATUS_NOSET;
			end
			ST_NORM: begin
				if (top_zero) begin
					x_q  <= x_q << shamt;
					lz_q <= lz_q + shamt;
				end
			end
			ST_IDX: begin
				idx_q <= (idx_raw >= ADDR_W'(LN_TABLE_DEPTH)) ?
				         ADDR_W'(LN_TABLE_DEPTH - 1) : idx_raw;
				rem_q <= p_q[FRAC_W-1:0];
			end
			ST_LO: lo_q <= tab_data;
			ST_HI: diff_q <= tab_data - lo_q;
			ST_LOG: begin
				if (!side_q) begin
					loga_q <= log_now;
					x_q    <= XW'({ground_q, {PRESSURE_FRAC_BITS{1'b0}}});
					lz_q   <= '0;
				end else begin
					dneg_q <= d_diff[LOG_W];
					dmag_q <= DMAG_W'(d_abs);
				end
			end
			ST_LN2: acc_q <= ACC_W'(p_q);
			ST_LN3: lm_q <= LM_W'(ln_adj >> LN2_SHIFT);
			ST_KT:  pm_q <= PM_W'(p_q);
			ST_P1:  acc_q <= ACC_W'(p_q);
			ST_P2:  acc_q <= acc_q + (ACC_W'(p_q) << LIMB_W);
			ST_P3:  acc_q <= acc_q + (ACC_W'(p_q) << LIMB_W);
			ST_P4:  acc_q <= acc_q + (ACC_W'(p_q) << (2 * LIMB_W));
			ST_FIN: begin
				alt_r_q <= alt_fin;
				st_r_q  <= st_fin;
			end
			ST_OUT: begin
				if (out_free) begin
					smoothed_q <= filt_q[XW-1:PRESSURE_FRAC_BITS];
					altitude_q <= alt_r_q;
					status_q   <= st_r_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/bae_chk.sv =====
// ----------------------------------------------------------------------------
// bae_chk
// Port-level checks of the barometric altitude filter, bound to the top.
// ----------------------------------------------------------------------------
module bae_chk
	import bae_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  sample_valid,
	input logic                  sample_stall,
	input logic [PRESSURE_W-1:0] raw_pressure,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic [PRESSURE_W-1:0] smoothed_pressure,
	input logic [ALT_W-1:0]      altitude,
	input logic [STATUS_W-1:0]   status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(altitude)
		&& $stable(status) && $stable(smoothed_pressure))
		else $error("stalled result changed");

	a_noset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STATUS_NOSET |-> altitude == '0)
		else $error("ground unset with nonzero altitude");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STATUS_SAT |->
		altitude == 32'h7fff_ffff || altitude == 32'h8000_0000)
		else $error("saturation flag without limit value");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && raw_pressure == '0 |=> !sample_stall)
		else $error("zero sample made the block busy");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && raw_pressure != '0 |=> sample_stall)
		else $error("nonzero sample did not start a run");

endmodule

bind baro_altitude_ema bae_chk u_bae_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.sample_valid      (sample_valid),
	.sample_stall      (sample_stall),
	.raw_pressure      (raw_pressure),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.smoothed_pressure (smoothed_pressure),
	.altitude          (altitude),
	.status            (status)
);
